[design/task_control_table_core_macros.svh]
// Assertion macros used by the task control table core.
`ifndef TASK_CONTROL_TABLE_CORE_MACROS_SVH
`define TASK_CONTROL_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define TCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("task control table: same-cycle check failed");
// Next-cycle implication, disabled while reset is held.
`define TCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("task control table: next-cycle check failed");
`else
`define TCT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/tct_pkg.sv]
// Shared constants, codes and structs of the task control table.
package tct_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ID_W        = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_ID_W    = 4;
    localparam int KIND_W      = 3;
    localparam int TID_W       = 8;
    localparam int WK_W        = 4;
    localparam int WO_W        = 32;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 56;

    typedef enum logic [KIND_W-1:0] {
        OP_CREATE = 3'd0,
        OP_SETCUR = 3'd1,
        OP_BLOCK  = 3'd2,
        OP_STOP   = 3'd3,
        OP_WAKE   = 3'd4,
        OP_GET    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_STOPPED = 2'd3
    } slot_state_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EXEC = 1'b1
    } ctl_state_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic              fire;
        op_t               op;
        logic              tgt_ok;
        logic [IDX_W-1:0]  tgt_idx;
        logic              cur_ok;
        logic [IDX_W-1:0]  cur_idx;
        logic              setcur_ok;
        slot_state_t       init;
        logic [WK_W-1:0]   wk;
        logic [WO_W-1:0]   wo;
    } cell_cmd_t;

    // Contents of one slot as seen from outside the cell.
    typedef struct packed {
        logic              active;
        slot_state_t       state;
        logic [WK_W-1:0]   wk;
        logic [WO_W-1:0]   wo;
    } cell_stat_t;

endpackage

[design/tct_cell.sv]
// One task slot of the table, with its link in the first-match claim chain.
module tct_cell
    import tct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] slot_idx,
    input  cell_cmd_t        cmd,
    input  logic             claim_in,
    output logic             claim_out,
    output logic             take,
    output cell_stat_t       stat
);

    logic              active_reg, active_next;
    slot_state_t       state_reg, state_next;
    logic [WK_W-1:0]   wk_reg, wk_next;
    logic [WO_W-1:0]   wo_reg, wo_next;
    logic              cand;
    logic              is_tgt;
    logic              is_cur;

    always_comb
    begin
        is_tgt = cmd.tgt_ok && (cmd.tgt_idx == slot_idx) && active_reg;
        is_cur = cmd.cur_ok && (cmd.cur_idx == slot_idx);
        case (cmd.op)
            OP_CREATE: cand = !active_reg;
            OP_WAKE:   cand = active_reg && (state_reg == ST_BLOCKED) &&
                              (wk_reg == cmd.wk) && (wo_reg == cmd.wo);
            default:   cand = 1'b0;
        endcase
        // earlier cells win; pass the claim on down the row
        take      = cand && !claim_in;
        claim_out = claim_in || cand;

        active_next = active_reg;
        state_next  = state_reg;
        wk_next     = wk_reg;
        wo_next     = wo_reg;
        if (cmd.fire)
        begin
            case (cmd.op)
                OP_CREATE:
                begin
                    if (take)
                    begin
                        active_next = 1'b1;
                        state_next  = cmd.init;
                        wk_next     = '0;
                        wo_next     = '0;
                    end
                end
                OP_SETCUR:
                begin
                    if (cmd.setcur_ok)
                    begin
                        if (is_tgt)
                            state_next = ST_RUNNING;
                        else if (is_cur && state_reg == ST_RUNNING)
                            state_next = ST_READY;
                    end
                end
                OP_BLOCK:
                begin
                    if (is_tgt && cmd.wk != '0 && cmd.wo != '0)
                    begin
                        state_next = ST_BLOCKED;
                        wk_next    = cmd.wk;
                        wo_next    = cmd.wo;
                    end
                end
                OP_STOP:
                begin
                    if (is_tgt)
                    begin
                        state_next = ST_STOPPED;
                        wk_next    = '0;
                        wo_next    = '0;
                    end
                end
                OP_WAKE:
                begin
                    if (take)
                    begin
                        state_next = ST_READY;
                        wk_next    = '0;
                        wo_next    = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        stat.active = active_reg;
        stat.state  = state_reg;
        stat.wk     = wk_reg;
        stat.wo     = wo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else
            active_reg <= active_next;
    end

    // slot payload is only read once the slot has been created
    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        wk_reg    <= wk_next;
        wo_reg    <= wo_next;
    end

endmodule

[design/task_control_table_core.sv]
// Top level of the task control table: command register, cell row and result register.
//
// Usage: one operation enters on the s_axis channel; the kind (create, set
// current, block, stop, wake, get) rides on tuser, its operands on tdata.
// Each operation gives exactly one result item on m_axis, carrying the status
// flag, the created, woken or read id, the entry read by get, the running
// task and the number of active slots after the operation.
// The block takes one item at a time: the next item is accepted only after
// the previous one executes. An item passes through the command register,
// then an execute step over the row of slot cells (the first-free and wake
// searches ripple through the row) that loads the result register.
// Reset clears every slot to inactive and the running task to none; no
// clearing pass is needed, so the block is ready right after reset.
// Receiver stall: the result register holds its item until m_axis_tready;
// a waiting command holds in the command register, and the input stays
// stalled until the result register frees up.
`include "task_control_table_core_macros.svh"
module task_control_table_core
    import tct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: task_id[7:0], initial_state[9:8], wait_class[13:10],
    //        wait_target[45:14], zero fill[47:46]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind[2:0]
    input  logic [KIND_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: ok[0], result_id[4:1], entry_state[6:5], entry_wait_class[10:7],
    //        entry_wait_target[42:11], running_task[46:43],
    //        active_count[50:47], zero fill[55:51]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    ctl_state_t              state_reg, state_next;
    op_t                     op_reg;
    logic [TID_W-1:0]        tid_reg;
    slot_state_t             init_reg;
    logic [WK_W-1:0]         wk_reg;
    logic [WO_W-1:0]         wo_reg;
    logic [ID_W-1:0]         cur_reg, cur_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    logic                    fire;
    logic                    out_free;
    logic [TID_W-1:0]        tid_m1;
    logic [ID_W-1:0]         cur_m1;
    cell_cmd_t               cmd;
    logic [TABLE_DEPTH:0]    claim;
    logic [TABLE_DEPTH-1:0]  take_vec;
    logic [TABLE_DEPTH-1:0]  active_vec;
    cell_stat_t              stat [TABLE_DEPTH];
    cell_stat_t              tgt_stat;
    logic                    tgt_live;
    logic                    ok;
    logic [ID_W-1:0]         rid;
    logic [ID_W-1:0]         found_id;
    logic [ID_W-1:0]         cnt;
    slot_state_t             es;
    logic [WK_W-1:0]         ewk;
    logic [WO_W-1:0]         ewo;

    // ---------------- handshake and control ----------------
    assign s_axis_tready = (state_reg == CS_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = (state_reg == CS_EXEC) && out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: if (s_axis_tvalid) state_next = CS_EXEC;
            CS_EXEC: if (out_free)      state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

    // Capture the command; it holds until the execute cycle fires.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg   <= op_t'(s_axis_tuser);
            tid_reg  <= s_axis_tdata[7:0];
            init_reg <= slot_state_t'(s_axis_tdata[9:8]);
            wk_reg   <= s_axis_tdata[13:10];
            wo_reg   <= s_axis_tdata[45:14];
        end
    end

    // ---------------- command broadcast ----------------
    assign tid_m1 = tid_reg - TID_W'(1);
    assign cur_m1 = cur_reg - ID_W'(1);

    always_comb
    begin
        cmd.fire    = fire;
        cmd.op      = op_reg;
        cmd.tgt_ok  = (tid_reg != '0) && (tid_reg <= TID_W'(TABLE_DEPTH));
        cmd.tgt_idx = tid_m1[IDX_W-1:0];
        cmd.cur_ok  = (cur_reg != '0);
        cmd.cur_idx = cur_m1[IDX_W-1:0];
        cmd.init    = init_reg;
        cmd.wk      = wk_reg;
        cmd.wo      = wo_reg;
        tgt_stat    = stat[cmd.tgt_idx];
        tgt_live    = cmd.tgt_ok && tgt_stat.active;
        // target must be an active ready or running task
        cmd.setcur_ok = tgt_live &&
                        (tgt_stat.state == ST_READY || tgt_stat.state == ST_RUNNING);
    end

    // ---------------- row of slot cells ----------------
    assign claim[0] = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        tct_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .slot_idx  (IDX_W'(i)),
            .cmd       (cmd),
            .claim_in  (claim[i]),
            .claim_out (claim[i+1]),
            .take      (take_vec[i]),
            .stat      (stat[i])
        );
        assign active_vec[i] = stat[i].active;
    end

    // ---------------- result assembly ----------------
    always_comb
    begin
        found_id = '0;
        cnt      = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (take_vec[i])
                found_id = ID_W'(i + 1);
            cnt = cnt + ID_W'(active_vec[i]);
        end

        ok       = 1'b0;
        rid      = '0;
        es       = ST_READY;
        ewk      = '0;
        ewo      = '0;
        cur_next = cur_reg;
        case (op_reg)
            OP_CREATE:
            begin
                ok  = claim[TABLE_DEPTH];
                rid = found_id;
                // the new slot counts after the operation
                cnt = cnt + ID_W'(claim[TABLE_DEPTH]);
            end
            OP_SETCUR:
            begin
                ok = cmd.setcur_ok;
                if (cmd.setcur_ok)
                    cur_next = ID_W'(tid_reg);
            end
            OP_BLOCK:
                ok = tgt_live && (wk_reg != '0) && (wo_reg != '0);
            OP_STOP:
                ok = tgt_live;
            OP_WAKE:
            begin
                ok  = claim[TABLE_DEPTH];
                rid = found_id;
            end
            OP_GET:
            begin
                if (tgt_live)
                begin
                    ok  = 1'b1;
                    rid = ID_W'(tid_reg);
                    es  = tgt_stat.state;
                    ewk = tgt_stat.wk;
                    ewo = tgt_stat.wo;
                end
            end
            default:
            begin
            end
        endcase

        out_data_next = {5'd0, OUT_ID_W'(cnt), OUT_ID_W'(cur_next), ewo, ewk, es,
                         OUT_ID_W'(rid), ok};

        out_valid_next = out_valid_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (fire)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                cur_reg <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result item until the receiver takes it
    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= out_data_next;
    end

    // ---------------- assertions ----------------
    // at most one slot is claimed by a create or wake search
    `TCT_ASSERT_NOW(a_one_claim, clk, rst_n, fire, $onehot0(take_vec))
    // the running task always names an active slot
    `TCT_ASSERT_NOW(a_cur_active, clk, rst_n, cur_reg != '0, active_vec[cmd.cur_idx])
    // slots are never freed
    `TCT_ASSERT_NEXT(a_no_free, clk, rst_n, 1'b1,
        $countones(active_vec) >= $past($countones(active_vec)))
    // an executed item always leaves a result waiting
    `TCT_ASSERT_NEXT(a_fire_result, clk, rst_n, fire, out_valid_reg)

endmodule
